// File: rtl/mqpd_pkg.sv
// ============================================================================
// mqpd_pkg
// Shared types, codes and default sizes of the priority dispatcher.
// ============================================================================
package mqpd_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int DEF_NUM_QUEUES  = 4;
    localparam int DEF_DEPTH       = 16;
    localparam int DEF_HANDLE_BITS = 16;

    // Operation codes.
    localparam logic [3:0] FN_ENQUEUE  = 4'd0;
    localparam logic [3:0] FN_COMPLETE = 4'd1;
    localparam logic [3:0] FN_PAUSE    = 4'd2;
    localparam logic [3:0] FN_RESUME   = 4'd3;
    localparam logic [3:0] FN_REMOVE   = 4'd4;
    localparam logic [3:0] FN_SET_LIM  = 4'd5;
    localparam logic [3:0] FN_EMPTY    = 4'd6;
    localparam logic [3:0] FN_FLUSH    = 4'd7;
    localparam logic [3:0] FN_GPAUSE   = 4'd8;
    localparam logic [3:0] FN_QUERY    = 4'd9;

    // Result kinds.
    localparam logic [1:0] KIND_DISPATCH = 2'd0;
    localparam logic [1:0] KIND_FINISHED = 2'd1;
    localparam logic [1:0] KIND_ACK      = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_TAG_NONE = 2'd2;

    // One result transaction.
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  queue;
        logic [15:0] handle;
        logic [7:0]  tag;
        logic [1:0]  status;
        logic [4:0]  length;
        logic [4:0]  limit;
        logic        paused;
        logic        busy;
        logic        gpaused;
        logic        last;
    } mqpd_result_t;

endpackage

// File: rtl/mqpd_ram.sv
// ============================================================================
// mqpd_ram
// Entry store: one write port, one read port, registered read data.
// ============================================================================
module mqpd_ram
    import mqpd_pkg::*;
#(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/mqpd_out_reg.sv
// ============================================================================
// mqpd_out_reg
// Output register holding one result transaction until it is taken.
// ============================================================================
module mqpd_out_reg
    import mqpd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  mqpd_result_t res_in,
    input  logic         stall,
    output logic         valid,
    output mqpd_result_t res_out,
    output logic         ready
);

    logic         valid_reg;
    mqpd_result_t res_reg;

    // A new result may be loaded when the slot is empty or being taken.
    assign ready   = !valid_reg || !stall;
    assign valid   = valid_reg;
    assign res_out = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

endmodule

// File: rtl/multi_queue_priority_dispatcher_unit.sv
// ============================================================================
// multi_queue_priority_dispatcher_unit
// Several bounded queues ordered by priority with stable insertion, holding
// their entries in one synchronous memory, and dispatching queue heads.
// ============================================================================
//
//  Channel | Handshake           | Payload
//  --------+---------------------+------------------------------------------
//  input   | in_valid / in_stall | func, queue_index, priority_req, event_tag,
//          |                     | event_handle, quantity, option_flag,
//          |                     | new_limit
//  output  | out_valid/out_stall | kind, out_queue, out_handle, out_tag,
//          |                     | status, length, limit, paused, busy_res,
//          |                     | global_paused_out, last
//
// One input transaction is worked on at a time. An operation that yields only
// its acknowledge passes through accept, decode and acknowledge. An enqueue
// walks the queue backwards from its tail, reading each entry examined from
// memory, then comparing and moving it, and writes the copies one by one. A
// removal by tag walks the whole queue, reading and then processing each entry.
// Examining a queue may end in a finished report or a dispatch (head read, pop
// and result load); a global resume passes over each empty queue and examines
// each other queue.
// Reset clears all queue state at once; the entry memory needs no clearing,
// since only slots below a queue's count are ever read.
// A stalled output holds the sequencer, which waits before loading the next
// result; the input is stalled until the acknowledge has been loaded.
//
module multi_queue_priority_dispatcher_unit
    import mqpd_pkg::*;
#(
    parameter int NUM_QUEUES  = DEF_NUM_QUEUES,
    parameter int DEPTH       = DEF_DEPTH,
    parameter int HANDLE_BITS = DEF_HANDLE_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [3:0]        func,
    input  logic [1:0]        queue_index,
    input  logic signed [7:0] priority_req,
    input  logic [7:0]        event_tag,
    input  logic [15:0]       event_handle,
    input  logic [4:0]        quantity,
    input  logic              option_flag,
    input  logic [4:0]        new_limit,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        kind,
    output logic [1:0]        out_queue,
    output logic [15:0]       out_handle,
    output logic [7:0]        out_tag,
    output logic [1:0]        status,
    output logic [4:0]        length,
    output logic [4:0]        limit,
    output logic              paused,
    output logic              busy_res,
    output logic              global_paused_out,
    output logic              last
);

    // Widths derived from the sizes.
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int SW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = 16 + HANDLE_BITS;
    localparam int AW = QW + SW;

    // Sequencer states, one-hot.
    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_DECODE = 14'b00000000000010,
        S_IRD    = 14'b00000000000100,
        S_IPROC  = 14'b00000000001000,
        S_FILL   = 14'b00000000010000,
        S_RRD    = 14'b00000000100000,
        S_RPROC  = 14'b00000001000000,
        S_EXAM   = 14'b00000010000000,
        S_XRD    = 14'b00000100000000,
        S_XPROC  = 14'b00001000000000,
        S_EMIT   = 14'b00010000000000,
        S_NEXT   = 14'b00100000000000,
        S_GSCAN  = 14'b01000000000000,
        S_ACK    = 14'b10000000000000
    } state_t;

    // Slot of a queue entry: ring position after the head, wrapped once.
    function automatic logic [SW-1:0] slot_at(input logic [SW-1:0] head,
                                              input logic [SW-1:0] off);
        logic [SW:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= (SW+1)'(DEPTH))
        begin
            sum = sum - (SW+1)'(DEPTH);
        end
        return sum[SW-1:0];
    endfunction

    // Queue index reduced modulo the number of queues (index is below four).
    function automatic logic [QW-1:0] queue_mod(input logic [1:0] v);
        logic [2:0] r;
        r = {1'b0, v};
        for (int k = 0; k < 3; k++)
        begin
            if (int'(r) >= NUM_QUEUES)
            begin
                r = 3'(int'(r) - NUM_QUEUES);
            end
        end
        return QW'(r);
    endfunction

    // Sequencer and operation registers.
    state_t             state_reg, state_next;
    logic [QW-1:0]      cq_reg, cq_next;
    logic [QW-1:0]      aq_reg, aq_next;
    logic               scan_reg, scan_next;
    logic [3:0]         func_reg, func_next;
    logic signed [7:0]  prio_reg, prio_next;
    logic [7:0]         tag_reg, tag_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    logic [4:0]         qty_reg, qty_next;
    logic               opt_reg, opt_next;
    logic [4:0]         nl_reg, nl_next;
    logic [1:0]         status_reg, status_next;
    logic [CW-1:0]      i_reg, i_next;
    logic [CW-1:0]      j_reg, j_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic [4:0]         left_reg, left_next;
    logic               rem_reg, rem_next;
    logic [1:0]         e_kind_reg, e_kind_next;
    logic [HANDLE_BITS-1:0] e_handle_reg, e_handle_next;
    logic [7:0]         e_tag_reg, e_tag_next;

    // Per-queue state.
    logic [CW-1:0]         count_reg [NUM_QUEUES];
    logic [CW-1:0]         count_next [NUM_QUEUES];
    logic [CW-1:0]         limit_reg [NUM_QUEUES];
    logic [CW-1:0]         limit_next [NUM_QUEUES];
    logic [SW-1:0]         head_reg [NUM_QUEUES];
    logic [SW-1:0]         head_next [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] paused_reg, paused_next;
    logic [NUM_QUEUES-1:0] busy_reg, busy_next;
    logic                  gp_reg, gp_next;

    // Memory port signals.
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [DW-1:0] mem_rdata;

    // Result path.
    logic         res_load;
    logic         res_ready;
    mqpd_result_t res_in;
    mqpd_result_t res_out;

    // Fields of the entry that was read, and state of the working queue.
    logic signed [7:0]      rd_prio;
    logic [7:0]             rd_tag;
    logic [HANDLE_BITS-1:0] rd_handle;
    logic [CW-1:0]          cur_count;
    logic [CW-1:0]          cur_limit;
    logic [SW-1:0]          cur_head;
    logic [CW-1:0]          i_less;
    logic [CW-1:0]          sat_limit;
    logic                   rm_match;

    assign rd_prio   = mem_rdata[DW-1 -: 8];
    assign rd_tag    = mem_rdata[DW-9 -: 8];
    assign rd_handle = mem_rdata[HANDLE_BITS-1:0];
    assign cur_count = count_reg[cq_reg];
    assign cur_limit = limit_reg[cq_reg];
    assign cur_head  = head_reg[cq_reg];
    assign i_less    = i_reg - CW'(1);
    assign sat_limit = (int'(nl_reg) > DEPTH) ? CW'(DEPTH) : CW'(nl_reg);
    assign rm_match  = (rd_tag == tag_reg) && (opt_reg || !rem_reg);

    assign in_stall = (state_reg != S_IDLE);

    // The result always reflects the working queue as it stands now.
    always_comb
    begin
        res_in.kind    = (state_reg == S_ACK) ? KIND_ACK : e_kind_reg;
        res_in.queue   = 2'(cq_reg);
        res_in.handle  = (state_reg == S_ACK) ? 16'd0 : 16'(e_handle_reg);
        res_in.tag     = (state_reg == S_ACK) ? 8'd0 : e_tag_reg;
        res_in.status  = (state_reg == S_ACK) ? status_reg : ST_OK;
        res_in.length  = 5'(cur_count);
        res_in.limit   = 5'(cur_limit);
        res_in.paused  = paused_reg[cq_reg];
        res_in.busy    = busy_reg[cq_reg];
        res_in.gpaused = gp_reg;
        res_in.last    = (state_reg == S_ACK);
    end

    // Read address: entry under the walk index, or the head for a dispatch.
    always_comb
    begin
        case (state_reg)
            S_IRD:   mem_raddr = {cq_reg, slot_at(cur_head, SW'(i_less))};
            S_RRD:   mem_raddr = {cq_reg, slot_at(cur_head, SW'(i_reg))};
            default: mem_raddr = {cq_reg, cur_head};
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        cq_next       = cq_reg;
        aq_next       = aq_reg;
        scan_next     = scan_reg;
        func_next     = func_reg;
        prio_next     = prio_reg;
        tag_next      = tag_reg;
        handle_next   = handle_reg;
        qty_next      = qty_reg;
        opt_next      = opt_reg;
        nl_next       = nl_reg;
        status_next   = status_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        pos_next      = pos_reg;
        left_next     = left_reg;
        rem_next      = rem_reg;
        e_kind_next   = e_kind_reg;
        e_handle_next = e_handle_reg;
        e_tag_next    = e_tag_reg;
        count_next    = count_reg;
        limit_next    = limit_reg;
        head_next     = head_reg;
        paused_next   = paused_reg;
        busy_next     = busy_reg;
        gp_next       = gp_reg;
        mem_we        = 1'b0;
        mem_waddr     = {cq_reg, cur_head};
        mem_wdata     = {prio_reg, tag_reg, handle_reg};
        res_load      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next   = func;
                    cq_next     = queue_mod(queue_index);
                    aq_next     = queue_mod(queue_index);
                    prio_next   = priority_req;
                    tag_next    = event_tag;
                    handle_next = HANDLE_BITS'(event_handle);
                    qty_next    = (quantity == 5'd0) ? 5'd1 : quantity;
                    opt_next    = option_flag;
                    nl_next     = new_limit;
                    status_next = ST_OK;
                    scan_next   = 1'b0;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                unique case (func_reg)
                    FN_ENQUEUE:
                    begin
                        if ((int'(cur_count) + int'(qty_reg) > int'(cur_limit)) ||
                            (int'(cur_count) + int'(qty_reg) > DEPTH))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_ACK;
                        end
                        else
                        begin
                            i_next    = cur_count;
                            left_next = qty_reg;
                            pos_next  = '0;
                            state_next = (cur_count == '0) ? S_FILL : S_IRD;
                        end
                    end
                    FN_COMPLETE:
                    begin
                        busy_next[cq_reg] = 1'b0;
                        state_next        = S_EXAM;
                    end
                    FN_PAUSE:
                    begin
                        paused_next[cq_reg] = 1'b1;
                        state_next          = S_ACK;
                    end
                    FN_RESUME:
                    begin
                        paused_next[cq_reg] = 1'b0;
                        state_next = (cur_count != '0) ? S_EXAM : S_ACK;
                    end
                    FN_REMOVE:
                    begin
                        i_next   = '0;
                        j_next   = '0;
                        rem_next = 1'b0;
                        if (tag_reg == 8'd0)
                        begin
                            status_next = ST_TAG_NONE;
                            state_next  = S_ACK;
                        end
                        else
                        begin
                            state_next = (cur_count == '0) ? S_ACK : S_RRD;
                        end
                    end
                    FN_SET_LIM:
                    begin
                        limit_next[cq_reg] = sat_limit;
                        if (opt_reg && (cur_count > sat_limit))
                        begin
                            count_next[cq_reg] = sat_limit;
                        end
                        state_next = S_ACK;
                    end
                    FN_EMPTY:
                    begin
                        count_next[cq_reg] = '0;
                        busy_next[cq_reg]  = 1'b0;
                        state_next         = S_ACK;
                    end
                    FN_FLUSH:
                    begin
                        for (int k = 0; k < NUM_QUEUES; k++)
                        begin
                            count_next[k] = '0;
                        end
                        state_next = S_ACK;
                    end
                    FN_GPAUSE:
                    begin
                        gp_next = opt_reg;
                        if (opt_reg)
                        begin
                            state_next = S_ACK;
                        end
                        else
                        begin
                            scan_next  = 1'b1;
                            cq_next    = '0;
                            state_next = S_GSCAN;
                        end
                    end
                    default:
                    begin
                        state_next = S_ACK;
                    end
                endcase
            end

            S_IRD:
            begin
                state_next = S_IPROC;
            end

            S_IPROC:
            begin
                // Entries of strictly higher priority move up by the copy count.
                if (rd_prio > prio_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = {cq_reg, slot_at(cur_head, SW'(i_less + CW'(qty_reg)))};
                    mem_wdata = mem_rdata;
                    i_next    = i_less;
                    if (i_less == '0)
                    begin
                        pos_next   = '0;
                        state_next = S_FILL;
                    end
                    else
                    begin
                        state_next = S_IRD;
                    end
                end
                else
                begin
                    pos_next   = i_reg;
                    state_next = S_FILL;
                end
            end

            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = {cq_reg, slot_at(cur_head, SW'(pos_reg))};
                pos_next  = pos_reg + CW'(1);
                left_next = left_reg - 5'd1;
                if (left_reg == 5'd1)
                begin
                    count_next[cq_reg] = cur_count + CW'(qty_reg);
                    state_next         = S_EXAM;
                end
            end

            S_RRD:
            begin
                state_next = S_RPROC;
            end

            S_RPROC:
            begin
                if (rm_match)
                begin
                    rem_next = 1'b1;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = {cq_reg, slot_at(cur_head, SW'(j_reg))};
                    mem_wdata = mem_rdata;
                    j_next    = j_reg + CW'(1);
                end
                i_next = i_reg + CW'(1);
                if ((CW+1)'(i_reg) + (CW+1)'(1) == (CW+1)'(cur_count))
                begin
                    count_next[cq_reg] = rm_match ? j_reg : (j_reg + CW'(1));
                    state_next         = S_ACK;
                end
                else
                begin
                    state_next = S_RRD;
                end
            end

            S_EXAM:
            begin
                if (cur_count == '0)
                begin
                    e_kind_next   = KIND_FINISHED;
                    e_handle_next = '0;
                    e_tag_next    = 8'd0;
                    state_next    = S_EMIT;
                end
                else if (busy_reg[cq_reg] || paused_reg[cq_reg] || gp_reg)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    state_next = S_XRD;
                end
            end

            S_XRD:
            begin
                state_next = S_XPROC;
            end

            S_XPROC:
            begin
                e_kind_next        = KIND_DISPATCH;
                e_handle_next      = rd_handle;
                e_tag_next         = rd_tag;
                head_next[cq_reg]  = slot_at(cur_head, SW'(1));
                count_next[cq_reg] = cur_count - CW'(1);
                busy_next[cq_reg]  = 1'b1;
                state_next         = S_EMIT;
            end

            S_EMIT:
            begin
                if (res_ready)
                begin
                    res_load   = 1'b1;
                    state_next = S_NEXT;
                end
            end

            S_NEXT:
            begin
                if (scan_reg && (cq_reg != QW'(NUM_QUEUES - 1)))
                begin
                    cq_next    = cq_reg + QW'(1);
                    state_next = S_GSCAN;
                end
                else
                begin
                    cq_next    = aq_reg;
                    scan_next  = 1'b0;
                    state_next = S_ACK;
                end
            end

            S_GSCAN:
            begin
                state_next = (cur_count != '0) ? S_EXAM : S_NEXT;
            end

            S_ACK:
            begin
                if (res_ready)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and queue state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            scan_reg   <= 1'b0;
            cq_reg     <= '0;
            gp_reg     <= 1'b0;
            paused_reg <= '0;
            busy_reg   <= '0;
            for (int k = 0; k < NUM_QUEUES; k++)
            begin
                count_reg[k] <= '0;
                limit_reg[k] <= CW'(DEPTH);
                head_reg[k]  <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            scan_reg   <= scan_next;
            cq_reg     <= cq_next;
            gp_reg     <= gp_next;
            paused_reg <= paused_next;
            busy_reg   <= busy_next;
            count_reg  <= count_next;
            limit_reg  <= limit_next;
            head_reg   <= head_next;
        end
    end

    // Operation payload and walk registers.
    always_ff @(posedge clk)
    begin
        aq_reg       <= aq_next;
        func_reg     <= func_next;
        prio_reg     <= prio_next;
        tag_reg      <= tag_next;
        handle_reg   <= handle_next;
        qty_reg      <= qty_next;
        opt_reg      <= opt_next;
        nl_reg       <= nl_next;
        status_reg   <= status_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        pos_reg      <= pos_next;
        left_reg     <= left_next;
        rem_reg      <= rem_next;
        e_kind_reg   <= e_kind_next;
        e_handle_reg <= e_handle_next;
        e_tag_reg    <= e_tag_next;
    end

    mqpd_ram #(
        .ADDR_W (AW),
        .DATA_W (DW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    mqpd_out_reg u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (res_load),
        .res_in  (res_in),
        .stall   (out_stall),
        .valid   (out_valid),
        .res_out (res_out),
        .ready   (res_ready)
    );

    assign kind              = res_out.kind;
    assign out_queue         = res_out.queue;
    assign out_handle        = res_out.handle;
    assign out_tag           = res_out.tag;
    assign status            = res_out.status;
    assign length            = res_out.length;
    assign limit             = res_out.limit;
    assign paused            = res_out.paused;
    assign busy_res          = res_out.busy;
    assign global_paused_out = res_out.gpaused;
    assign last              = res_out.last;

`ifndef ASSERT_OFF
    // An accepted transaction keeps the input stalled while it is worked on.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after an accepted transaction");

    // Whenever a new transaction may enter, any pending result is an acknowledge.
    a_idle_pending_is_ack: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid || last)
        else $error("non-final result pending while the sequencer is idle");

    // The working queue never holds more than its capacity.
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        int'(cur_count) <= DEPTH)
        else $error("queue count above capacity");
`endif

endmodule
